// File: src/wrs_pkg.sv
// wrs_pkg: shared types, constants and helpers of the whitespace retab stream
// used by every module of the block; depends on nothing

package wrs_pkg;

  // column counter width and derived sizes
  localparam int COLUMN_BITS = 16;
  localparam int CountW      = 16;
  localparam int StopW       = 8;
  localparam int CharW       = 8;
  localparam int DivCntW     = $clog2(COLUMN_BITS + 1);

  // small queues between the parts
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // configuration port
  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  localparam logic [CharW-1:0]  TabCode   = 8'd9;
  localparam logic [CharW-1:0]  SpaceCode = 8'd32;
  localparam logic [CountW-1:0] CountMax  = 16'hFFFF;

  localparam logic [StopW-1:0] OldTabStopReset = 8'd8;
  localparam logic [StopW-1:0] NewTabStopReset = 8'd0;

  // register indexes
  typedef enum logic [1:0] {
    REG_OLD_TAB_STOP = 2'd0,
    REG_NEW_TAB_STOP = 2'd1,
    REG_EXPAND_TABS  = 2'd2,
    REG_FORCE_PACK   = 2'd3
  } reg_idx_e;

  // classified input item
  typedef enum logic [1:0] {
    OP_SPACE = 2'd0,
    OP_TAB   = 2'd1,
    OP_CHAR  = 2'd2,
    OP_EOL   = 2'd3
  } op_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_EOL  = 2'd2
  } kind_e;

  // back part sequencer
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_TAB_WAIT,
    BS_FIRST_WAIT,
    BS_REST_DIV,
    BS_REST_WAIT,
    BS_EMIT_RUN,
    BS_EMIT_LAST
  } back_state_e;

  typedef struct packed {
    logic [StopW-1:0] old_tab_stop;
    logic [StopW-1:0] new_tab_stop;
    logic             expand_tabs;
    logic             force_pack;
  } cfg_t;

  typedef struct packed {
    op_e              code;
    logic [CharW-1:0] ch;
  } op_t;

  typedef struct packed {
    kind_e             kind;
    logic [CharW-1:0]  out_char;
    logic [CountW-1:0] tab_count;
    logic [CountW-1:0] space_count;
    logic              rewritten;
    logic              last;
  } res_t;

  typedef struct packed {
    logic                   start;
    logic [COLUMN_BITS-1:0] dividend;
    logic [StopW-1:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [COLUMN_BITS-1:0] quotient;
    logic [StopW-1:0]       remainder;
  } div_rsp_t;

  // saturating column add
  function automatic logic [COLUMN_BITS-1:0] col_add(input logic [COLUMN_BITS-1:0] c,
                                                     input logic [StopW-1:0] d);
    logic [COLUMN_BITS:0] s;
    s = {1'b0, c} + (COLUMN_BITS + 1)'(d);
    return s[COLUMN_BITS] ? '1 : s[COLUMN_BITS-1:0];
  endfunction

  // clamp a column-wide count to the result field width
  function automatic logic [CountW-1:0] sat_count(input logic [COLUMN_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'(CountMax)) ? CountMax : w[CountW-1:0];
  endfunction

  // next queue pointer
  function automatic logic [QueuePtrW-1:0] ptr_inc(input logic [QueuePtrW-1:0] p);
    return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + QueuePtrW'(1);
  endfunction

endpackage

// File: src/wrs_regs.sv
// wrs_regs: configuration registers behind the apb-style port
// depends on wrs_pkg

module wrs_regs
  import wrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;

  // register write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_OLD_TAB_STOP: cfg_d.old_tab_stop = pwdata[StopW-1:0];
        REG_NEW_TAB_STOP: cfg_d.new_tab_stop = pwdata[StopW-1:0];
        REG_EXPAND_TABS:  cfg_d.expand_tabs  = pwdata[0];
        REG_FORCE_PACK:   cfg_d.force_pack   = pwdata[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.old_tab_stop <= OldTabStopReset;
      cfg_q.new_tab_stop <= NewTabStopReset;
      cfg_q.expand_tabs  <= 1'b0;
      cfg_q.force_pack   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_OLD_TAB_STOP: prdata = ApbDataW'(cfg_q.old_tab_stop);
      REG_NEW_TAB_STOP: prdata = ApbDataW'(cfg_q.new_tab_stop);
      REG_EXPAND_TABS:  prdata = ApbDataW'(cfg_q.expand_tabs);
      REG_FORCE_PACK:   prdata = ApbDataW'(cfg_q.force_pack);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/wrs_front.sv
// wrs_front: accepts input bytes, classifies them and queues the operations
// depends on wrs_pkg

module wrs_front
  import wrs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [CharW-1:0] char_code_i,
  input  logic             end_of_line_i,
  output logic             op_valid_o,
  output op_t              op_o,
  input  logic             op_pop_i
);

  op_t                  op_mem [QueueDepth];
  op_t                  op_in;
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 wr_en;
  logic                 rd_en;

  // classify the byte
  always_comb begin
    op_in.ch = char_code_i;
    priority if (end_of_line_i) begin
      op_in.code = OP_EOL;
    end else if (char_code_i == SpaceCode) begin
      op_in.code = OP_SPACE;
    end else if (char_code_i == TabCode) begin
      op_in.code = OP_TAB;
    end else begin
      op_in.code = OP_CHAR;
    end
  end

  assign full_o     = (cnt_q == QueueCntW'(QueueDepth));
  assign op_valid_o = (cnt_q != '0);
  assign wr_en      = push_i & ~full_o;
  assign rd_en      = op_pop_i & op_valid_o;
  assign op_o       = op_mem[rd_ptr_q];

  // queue pointers
  always_comb begin
    wr_ptr_d = wr_en ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_en ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + QueueCntW'(wr_en) - QueueCntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      op_mem[wr_ptr_q] <= op_in;
    end
  end

endmodule

// File: src/wrs_divider.sv
// wrs_divider: restoring divider, one quotient bit per cycle
// depends on wrs_pkg

module wrs_divider
  import wrs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [COLUMN_BITS-1:0] quo_q, quo_d;
  logic [StopW-1:0]       rem_q, rem_d;
  logic [StopW-1:0]       div_q, div_d;
  logic [DivCntW-1:0]     cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [StopW:0]         trial;
  logic [StopW:0]         diff;
  logic                   ge;

  // one trial subtraction
  always_comb begin
    trial = {rem_q, quo_q[COLUMN_BITS-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
  end

  // iteration control
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
      cnt_d  = DivCntW'(COLUMN_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[COLUMN_BITS-2:0], ge};
      rem_d = ge ? diff[StopW-1:0] : trial[StopW-1:0];
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: src/wrs_back.sv
// wrs_back: column tracking, run collection and run rewriting, plus result queue
// depends on wrs_pkg and wrs_divider

module wrs_back
  import wrs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  op_valid_i,
  input  op_t   op_i,
  output logic  op_pop_o,
  output logic  empty_o,
  input  logic  pop_i,
  output res_t  res_o
);

  back_state_e state_q, state_d;

  logic [COLUMN_BITS-1:0] column_q, column_d;
  logic [COLUMN_BITS-1:0] run_start_q, run_start_d;
  logic [CountW-1:0]      run_spaces_q, run_spaces_d;
  logic                   run_tab_q, run_tab_d;
  logic [COLUMN_BITS-1:0] tabs_q, tabs_d;
  logic [COLUMN_BITS-1:0] spaces_q, spaces_d;

  logic [StopW-1:0]       ots;
  logic [StopW-1:0]       ts;
  logic [StopW-1:0]       first;
  logic [COLUMN_BITS-1:0] len;
  logic [COLUMN_BITS:0]   packed_len;
  logic                   pending;
  logic                   rew;

  div_req_t div_req;
  div_rsp_t div_rsp;

  res_t                 res_in;
  logic                 res_push;
  logic                 res_full;
  res_t                 res_mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 wr_en;
  logic                 rd_en;

  wrs_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // effective tab stops and run figures
  always_comb begin
    ots        = (cfg_i.old_tab_stop == '0) ? StopW'(1) : cfg_i.old_tab_stop;
    ts         = (cfg_i.new_tab_stop == '0) ? ots : cfg_i.new_tab_stop;
    pending    = run_tab_q | (run_spaces_q != '0);
    len        = (column_q >= run_start_q) ? column_q - run_start_q : '0;
    first      = ts - div_rsp.remainder;
    packed_len = {1'b0, tabs_q} + {1'b0, spaces_q};
    rew        = run_tab_q |
                 (cfg_i.force_pack & (run_spaces_q > CountW'(1)) &
                  (cfg_i.expand_tabs | (packed_len < {1'b0, len})));
  end

  // sequencer and datapath next values
  always_comb begin
    state_d      = state_q;
    column_d     = column_q;
    run_start_d  = run_start_q;
    run_spaces_d = run_spaces_q;
    run_tab_d    = run_tab_q;
    tabs_d       = tabs_q;
    spaces_d     = spaces_q;
    div_req      = '0;
    op_pop_o     = 1'b0;
    res_push     = 1'b0;
    res_in       = '0;
    unique case (state_q)
      BS_IDLE: begin
        if (op_valid_i) begin
          unique case (op_i.code)
            OP_SPACE: begin
              if (!pending) begin
                run_start_d = column_q;
              end
              if (run_spaces_q != CountMax) begin
                run_spaces_d = run_spaces_q + CountW'(1);
              end
              column_d = col_add(column_q, StopW'(1));
              op_pop_o = 1'b1;
            end
            OP_TAB: begin
              div_req.start    = 1'b1;
              div_req.dividend = column_q;
              div_req.divisor  = ots;
              state_d          = BS_TAB_WAIT;
            end
            OP_CHAR, OP_EOL: begin
              if (!pending) begin
                state_d = BS_EMIT_LAST;
              end else if (cfg_i.expand_tabs) begin
                tabs_d   = '0;
                spaces_d = len;
                state_d  = BS_EMIT_RUN;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = run_start_q;
                div_req.divisor  = ts;
                state_d          = BS_FIRST_WAIT;
              end
            end
            default: state_d = BS_IDLE;
          endcase
        end
      end
      // tab: move to the next old tab stop
      BS_TAB_WAIT: begin
        if (div_rsp.done) begin
          if (!pending) begin
            run_start_d = column_q;
          end
          column_d  = col_add(column_q, ots - div_rsp.remainder);
          run_tab_d = 1'b1;
          op_pop_o  = 1'b1;
          state_d   = BS_IDLE;
        end
      end
      // leading partial tab up to the first new stop
      BS_FIRST_WAIT: begin
        if (div_rsp.done) begin
          if (len >= COLUMN_BITS'(first)) begin
            spaces_d = len - COLUMN_BITS'(first);
            tabs_d   = COLUMN_BITS'(1);
          end else begin
            spaces_d = len;
            tabs_d   = '0;
          end
          state_d = BS_REST_DIV;
        end
      end
      BS_REST_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = spaces_q;
        div_req.divisor  = ts;
        state_d          = BS_REST_WAIT;
      end
      // whole tabs and leftover spaces
      BS_REST_WAIT: begin
        if (div_rsp.done) begin
          tabs_d   = tabs_q + div_rsp.quotient;
          spaces_d = COLUMN_BITS'(div_rsp.remainder);
          state_d  = BS_EMIT_RUN;
        end
      end
      BS_EMIT_RUN: begin
        if (!res_full) begin
          res_push      = 1'b1;
          res_in.kind   = KIND_RUN;
          res_in.last   = 1'b0;
          if (rew) begin
            res_in.tab_count   = sat_count(tabs_q);
            res_in.space_count = sat_count(spaces_q);
            res_in.rewritten   = 1'b1;
          end else begin
            res_in.space_count = run_spaces_q;
          end
          state_d = BS_EMIT_LAST;
        end
      end
      // passed character or end of line, closes the run
      BS_EMIT_LAST: begin
        if (!res_full) begin
          res_push    = 1'b1;
          res_in.last = 1'b1;
          if (op_i.code == OP_EOL) begin
            res_in.kind = KIND_EOL;
            column_d    = '0;
          end else begin
            res_in.kind     = KIND_CHAR;
            res_in.out_char = op_i.ch;
            column_d        = col_add(column_q, StopW'(1));
          end
          run_start_d  = '0;
          run_spaces_d = '0;
          run_tab_d    = 1'b0;
          op_pop_o     = 1'b1;
          state_d      = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q     <= '0;
      run_start_q  <= '0;
      run_spaces_q <= '0;
      run_tab_q    <= 1'b0;
    end else begin
      column_q     <= column_d;
      run_start_q  <= run_start_d;
      run_spaces_q <= run_spaces_d;
      run_tab_q    <= run_tab_d;
    end
  end

  // run working registers
  always_ff @(posedge clk_i) begin
    tabs_q   <= tabs_d;
    spaces_q <= spaces_d;
  end

  // result queue
  assign res_full = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o  = (cnt_q == '0);
  assign wr_en    = res_push & ~res_full;
  assign rd_en    = pop_i & ~empty_o;
  assign res_o    = res_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_en ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + QueueCntW'(wr_en) - QueueCntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      res_mem[wr_ptr_q] <= res_in;
    end
  end

endmodule

// File: src/whitespace_retab_stream_unit.sv
// whitespace_retab_stream_unit: top level; a space is taken straight from the idle state of the back part,
// a tab waits for one division by the old tab stop, a closing run with packing for two divisions by the
// new tab stop, all done by the one-bit-per-cycle divider; a plain character goes through the emit state.
// Reset clears the queues, the column and the run; registers return to their defaults.
// depends on wrs_pkg, wrs_regs, wrs_front, wrs_back

module whitespace_retab_stream_unit
  import wrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  // input side
  input  logic                push,
  output logic                full,
  input  logic [CharW-1:0]    char_code_i,
  input  logic                end_of_line_i,
  // result side
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          kind_o,
  output logic [CharW-1:0]    out_char_o,
  output logic [CountW-1:0]   tab_count_o,
  output logic [CountW-1:0]   space_count_o,
  output logic                rewritten_o,
  output logic                last_o
);

  cfg_t cfg;
  op_t  op;
  logic op_valid;
  logic op_pop;
  res_t res;

  wrs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wrs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .char_code_i   (char_code_i),
    .end_of_line_i (end_of_line_i),
    .op_valid_o    (op_valid),
    .op_o          (op),
    .op_pop_i      (op_pop)
  );

  wrs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_pop_o   (op_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res)
  );

  // result fields
  assign kind_o        = res.kind;
  assign out_char_o    = res.out_char;
  assign tab_count_o   = res.tab_count;
  assign space_count_o = res.space_count;
  assign rewritten_o   = res.rewritten;
  assign last_o        = res.last;

endmodule
